// ----- rtl/core/vwfi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vwfi_pkg
// Shared types and constants for the vertex weld fan indexer.
// -----------------------------------------------------------------------------
package vwfi_pkg;

   // Table geometry; TABLE_ENTRIES must be a power of two (slot wraps by mask)
   localparam int TABLE_ENTRIES = 4096;
   localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
   localparam int COUNT_BITS    = SLOT_BITS + 1;
   localparam int INDEX_BITS    = 20;
   localparam int FIELD_BITS    = 20;
   localparam int VERTEX_BITS   = 12;
   localparam int HASH_BITS     = 32;

   // Corner select while walking a triangle
   localparam logic [1:0] SEL_FIRST = 2'd0;
   localparam logic [1:0] SEL_PREV  = 2'd1;
   localparam logic [1:0] SEL_CUR   = 2'd2;

   typedef struct packed {
      logic [INDEX_BITS-1:0] pos;
      logic [INDEX_BITS-1:0] uv;
      logic [INDEX_BITS-1:0] normal;
   } corner_type;

   typedef struct packed {
      logic                  mode;
      logic [FIELD_BITS-1:0] pos_index;
      logic [FIELD_BITS-1:0] uv_index;
      logic [FIELD_BITS-1:0] normal_index;
      logic                  face_end;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] vertex_index;
      logic                   is_new;
      logic [FIELD_BITS-1:0]  out_pos;
      logic [FIELD_BITS-1:0]  out_uv;
      logic [FIELD_BITS-1:0]  out_normal;
      logic                   overflow;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      corner_type           key;
      logic [SLOT_BITS-1:0] number;
   } entry_type;

   typedef struct packed {
      logic       lookup;
      logic       clear;
      corner_type key;
   } tbl_cmd_type;

   typedef struct packed {
      logic                 ready;
      logic                 done;
      logic [SLOT_BITS-1:0] number;
      logic                 is_new;
      logic                 overflow;
   } tbl_stat_type;

   typedef enum logic [1:0] {
      LK_CLEAR,
      LK_IDLE,
      LK_READ,
      LK_CHECK
   } lkp_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } top_state_type;

endpackage
`default_nettype wire

// ----- rtl/core/vwfi_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vwfi_table
// Hashed vertex table with linear probing: one read-compare per probe step,
// insert on the first empty slot, and a sweep that clears every slot.
// -----------------------------------------------------------------------------
module vwfi_table import vwfi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tbl_cmd_type  cmd,
   output tbl_stat_type stat
);

   localparam logic [COUNT_BITS-1:0] ENTRIES_COUNT = COUNT_BITS'(TABLE_ENTRIES);

   entry_type mem [TABLE_ENTRIES];

   lkp_state_type        state_ff, state_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOT_BITS-1:0] probe_ff, probe_in;
   logic [COUNT_BITS-1:0] next_ff, next_in;
   corner_type           key_ff, key_in;
   logic                 done_ff, done_in;
   logic [SLOT_BITS-1:0] number_ff, number_in;
   logic                 new_ff, new_in;
   logic                 ovf_ff, ovf_in;
   entry_type            rd_ff;

   logic                 wr_en;
   entry_type            wr_data;
   logic                 hit;

   function automatic logic [SLOT_BITS-1:0] hash_slot(input corner_type c);
      logic [HASH_BITS-1:0] h;
      h = HASH_BITS'(c.pos) ^ (HASH_BITS'(c.uv) << 1) ^ (HASH_BITS'(c.normal) << 2);
      return h[SLOT_BITS-1:0];
   endfunction

   assign hit = rd_ff.valid && (rd_ff.key == key_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LK_CLEAR: begin
            if (slot_ff == '1) state_in = LK_IDLE;
         end
         LK_IDLE: begin
            if (cmd.clear)       state_in = LK_CLEAR;
            else if (cmd.lookup) state_in = LK_READ;
         end
         LK_READ: state_in = LK_CHECK;
         LK_CHECK: begin
            if (!rd_ff.valid || hit || probe_ff == '1) state_in = LK_IDLE;
            else                                       state_in = LK_READ;
         end
         default: state_in = LK_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      slot_in   = slot_ff;
      probe_in  = probe_ff;
      next_in   = next_ff;
      key_in    = key_ff;
      done_in   = 1'b0;
      number_in = number_ff;
      new_in    = 1'b0;
      ovf_in    = 1'b0;
      wr_en     = 1'b0;
      wr_data   = '0;
      unique case (state_ff)
         LK_CLEAR: begin
            wr_en   = 1'b1;
            slot_in = slot_ff + 1'b1;
         end
         LK_IDLE: begin
            if (cmd.clear) begin
               slot_in = '0;
               next_in = '0;
            end else if (cmd.lookup) begin
               slot_in  = hash_slot(cmd.key);
               key_in   = cmd.key;
               probe_in = '0;
            end
         end
         LK_READ: begin
         end
         LK_CHECK: begin
            if (!rd_ff.valid) begin
               done_in = 1'b1;
               if (next_ff < ENTRIES_COUNT) begin
                  wr_en          = 1'b1;
                  wr_data.valid  = 1'b1;
                  wr_data.key    = key_ff;
                  wr_data.number = next_ff[SLOT_BITS-1:0];
                  number_in      = next_ff[SLOT_BITS-1:0];
                  new_in         = 1'b1;
                  next_in        = next_ff + 1'b1;
               end else begin
                  ovf_in    = 1'b1;
                  number_in = '0;
               end
            end else if (hit) begin
               done_in   = 1'b1;
               number_in = rd_ff.number;
            end else if (probe_ff == '1) begin
               // every slot tried: table is full
               done_in   = 1'b1;
               ovf_in    = 1'b1;
               number_in = '0;
            end else begin
               slot_in  = slot_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign stat.ready    = (state_ff == LK_IDLE);
   assign stat.done     = done_ff;
   assign stat.number   = number_ff;
   assign stat.is_new   = new_ff;
   assign stat.overflow = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LK_CLEAR;
         slot_ff  <= '0;
         next_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         next_ff  <= next_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff  <= probe_in;
      key_ff    <= key_in;
      number_ff <= number_in;
      new_ff    <= new_in;
      ovf_ff    <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[slot_ff] <= wr_data;
      rd_ff <= mem[slot_ff];
   end

endmodule
`default_nettype wire

// ----- rtl/core/vertex_weld_fan_indexer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vertex_weld_fan_indexer
// Fan-triangulates face corners and welds identical corners into one vertex
// number through a hashed, linearly probed table.
// -----------------------------------------------------------------------------
//   channel   ports                   handshake
//   request   start, busy, req_data   beat taken when start & !busy
//   result    rsp_strobe, rsp_data    one-cycle strobe, no back-pressure
//
// A corner that completes no triangle is only recorded and gives no result. A
// triangle corner is accepted and then resolved by three table lookups on the
// single table port: first, previous and current corner, in that order.
// A new-mesh beat sweeps the table one slot a cycle.
// The same sweep runs after reset, with busy high throughout.
// Results cannot be stalled.
// -----------------------------------------------------------------------------
module vertex_weld_fan_indexer import vwfi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   top_state_type state_ff, state_in;
   logic [1:0]    count_ff, count_in;
   corner_type    first_ff, first_in;
   corner_type    prev_ff, prev_in;
   corner_type    cur_ff, cur_in;
   logic [1:0]    pick_ff, pick_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   tbl_cmd_type   tbl_cmd;
   tbl_stat_type  tbl_stat;

   logic          accept;
   logic          lookup_done;
   corner_type    in_corner;
   corner_type    sel_key;

   vwfi_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .stat  (tbl_stat)
   );

   assign accept      = start && !busy;
   assign lookup_done = (state_ff == ST_WAIT) && tbl_stat.done;

   assign in_corner.pos    = INDEX_BITS'(req_data.pos_index);
   assign in_corner.uv     = INDEX_BITS'(req_data.uv_index);
   assign in_corner.normal = INDEX_BITS'(req_data.normal_index);

   always_comb begin
      case (pick_ff)
         SEL_FIRST: sel_key = first_ff;
         SEL_PREV:  sel_key = prev_ff;
         default:   sel_key = cur_ff;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_data.mode && count_ff == 2'd2) state_in = ST_ISSUE;
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (tbl_stat.done) state_in = (pick_ff == SEL_CUR) ? ST_IDLE : ST_ISSUE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy           = (state_ff != ST_IDLE) || !tbl_stat.ready;
      tbl_cmd.lookup = (state_ff == ST_ISSUE);
      tbl_cmd.clear  = accept && req_data.mode;
      tbl_cmd.key    = sel_key;
   end

   // Face tracking and result assembly
   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      pick_in  = pick_ff;
      if (accept) begin
         if (req_data.mode) begin
            count_in = 2'd0;
         end else begin
            case (count_ff)
               2'd0: begin
                  first_in = in_corner;
                  prev_in  = in_corner;
                  count_in = 2'd1;
               end
               2'd1: begin
                  prev_in  = in_corner;
                  count_in = 2'd2;
               end
               default: begin
                  cur_in  = in_corner;
                  pick_in = SEL_FIRST;
               end
            endcase
            if (req_data.face_end) count_in = 2'd0;
         end
      end
      if (lookup_done) begin
         // advance to the next corner of the triangle, or roll prev forward
         if (pick_ff == SEL_CUR) prev_in = cur_ff;
         else                    pick_in = pick_ff + 1'b1;
      end

      strobe_in           = lookup_done;
      rsp_in              = rsp_ff;
      if (lookup_done) begin
         rsp_in.vertex_index = VERTEX_BITS'(tbl_stat.number);
         rsp_in.is_new       = tbl_stat.is_new;
         rsp_in.out_pos      = FIELD_BITS'(sel_key.pos);
         rsp_in.out_uv       = FIELD_BITS'(sel_key.uv);
         rsp_in.out_normal   = FIELD_BITS'(sel_key.normal);
         rsp_in.overflow     = tbl_stat.overflow;
         rsp_in.last         = (pick_ff == SEL_CUR);
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= 2'd0;
         first_ff  <= '0;
         prev_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         prev_ff   <= prev_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      pick_ff <= pick_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/vwfi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vwfi_checker
// Port-level checks on the vertex weld fan indexer, bound to the top level.
// -----------------------------------------------------------------------------
module vwfi_checker import vwfi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // table sweep follows reset
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_mesh_sweep: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode) |=> busy)
      else $error("new mesh beat did not start table sweep");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("result beat without work in flight");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats back to back");

   // a vertex that found no room is never flagged new
   a_ovf_not_new: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.overflow && rsp_data.is_new))
      else $error("overflow beat flagged new");

endmodule

bind vertex_weld_fan_indexer vwfi_checker u_vwfi_checker (.*);
`default_nettype wire
